// File: rtl/fifo_associative_cache_lookup_top_macros.svh
// Assertion macros for the associative cache lookup block.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef FIFO_ASSOCIATIVE_CACHE_LOOKUP_TOP_MACROS_SVH
`define FIFO_ASSOCIATIVE_CACHE_LOOKUP_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define FACL_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("cache lookup assertion failed");
`define FACL_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cache lookup assertion failed");
`define FACL_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cache lookup assertion failed");
`else
`define FACL_ASSERT(name, prop)
`define FACL_ASSERT_IMP(name, ante, cons)
`define FACL_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// File: rtl/facl_pkg.sv
// Shared constants and types of the associative cache lookup block.
// No dependencies; used by the cell, the output stage, the top level and the testbench.
package facl_pkg;

  localparam int unsigned ENTRIES    = 16;  // 2 .. 256
  localparam int unsigned KEY_BITS   = 32;  // 1 .. FIELD_BITS
  localparam int unsigned DATA_BITS  = 32;  // 1 .. FIELD_BITS
  localparam int unsigned FIELD_BITS = 32;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [DATA_BITS-1:0]  data_t;
  typedef logic [FIELD_BITS-1:0] field_t;

  // What one cell holds and hands to its neighbor.
  typedef struct packed {
    logic  valid;
    key_t  key;
    data_t data;
  } cell_link_t;

endpackage

// File: rtl/facl_cell.sv
// One storage cell of the cache row: holds a key, a value and a valid flag.
// Depends on facl_pkg.
module facl_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_i,
  input  facl_pkg::cell_link_t prev_i,
  input  facl_pkg::key_t      lookup_key_i,
  output facl_pkg::cell_link_t cell_o,
  output logic                match_o
);
  import facl_pkg::*;

  logic  valid_q, valid_d;
  key_t  key_q, key_d;
  data_t data_q, data_d;

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    data_d  = data_q;
    if (shift_i) begin
      valid_d = prev_i.valid;
      key_d   = prev_i.key;
      data_d  = prev_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    data_q <= data_d;
  end

  assign match_o      = valid_q && (key_q == lookup_key_i);
  assign cell_o.valid = valid_q;
  assign cell_o.key   = key_q;
  assign cell_o.data  = data_q;

endmodule

// File: rtl/facl_out_stage.sv
// Output register of the cache lookup: holds one result item until taken.
// Depends on facl_pkg.
module facl_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  facl_pkg::field_t read_data_i,
  input  logic             hit_i,
  input  logic             evicted_i,
  input  logic             out_stall_i,
  output logic             busy_o,
  output logic             out_valid_o,
  output facl_pkg::field_t read_data_o,
  output logic             hit_o,
  output logic             evicted_o
);
  import facl_pkg::*;

  logic   valid_q, valid_d;
  field_t data_q;
  logic   hit_q, evicted_q;

  assign valid_d = load_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q    <= read_data_i;
      hit_q     <= hit_i;
      evicted_q <= evicted_i;
    end
  end

  // A held item that is not being taken blocks a new one.
  assign busy_o      = valid_q && out_stall_i;
  assign out_valid_o = valid_q;
  assign read_data_o = data_q;
  assign hit_o       = hit_q;
  assign evicted_o   = evicted_q;

endmodule

// File: rtl/fifo_associative_cache_lookup_top.sv
// Fully associative cache with FIFO replacement, built as a row of cells.
// An accepted item's result is in the output register in the next cycle.
// Throughput: one item per cycle unless a held result is stalled; all cells
// compare in parallel and the row shifts by one cell on a miss within the same cycle.
// Reset clears every cell's valid flag and the output register's valid flag;
// stored keys, values and result fields are not cleared and need no clearing pass.
`include "fifo_associative_cache_lookup_top_macros.svh"

module fifo_associative_cache_lookup_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  facl_pkg::field_t lookup_key_i,
  input  facl_pkg::field_t source_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output facl_pkg::field_t read_data_o,
  output logic             hit_o,
  output logic             evicted_o
);
  import facl_pkg::*;

  key_t               key;
  data_t              data;
  logic               in_accept;
  logic               busy;
  logic               hit;
  logic               evicted;
  logic               shift;
  logic [ENTRIES-1:0] match_vec;
  logic [ENTRIES-1:0] valid_vec;
  data_t              hit_data;
  field_t             result_data;
  cell_link_t         links [ENTRIES];
  cell_link_t         prev_links [ENTRIES];

  assign key       = lookup_key_i[KEY_BITS-1:0];
  assign data      = source_data_i[DATA_BITS-1:0];
  assign in_stall_o = busy;
  assign in_accept = in_valid_i && !busy;

  // The newest entry enters at cell 0; the oldest sits in the highest valid cell.
  always_comb begin
    prev_links[0].valid = 1'b1;
    prev_links[0].key   = key;
    prev_links[0].data  = data;
    for (int unsigned i = 1; i < ENTRIES; i++) begin
      prev_links[i] = links[i-1];
    end
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    facl_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .shift_i      (shift),
      .prev_i       (prev_links[g]),
      .lookup_key_i (key),
      .cell_o       (links[g]),
      .match_o      (match_vec[g])
    );
    assign valid_vec[g] = links[g].valid;
  end

  // Keys are inserted only on a miss, so at most one cell matches.
  always_comb begin
    hit_data = '0;
    for (int unsigned i = 0; i < ENTRIES; i++) begin
      hit_data = hit_data | ({DATA_BITS{match_vec[i]}} & links[i].data);
    end
  end

  assign hit         = |match_vec;
  assign shift       = in_accept && !hit;
  assign evicted     = !hit && valid_vec[ENTRIES-1];
  assign result_data = FIELD_BITS'(hit ? hit_data : data);

  facl_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_accept),
    .read_data_i (result_data),
    .hit_i       (hit),
    .evicted_i   (evicted),
    .out_stall_i (out_stall_i),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .read_data_o (read_data_o),
    .hit_o       (hit_o),
    .evicted_o   (evicted_o)
  );

  `FACL_ASSERT(a_match_unique, $onehot0(match_vec))
  `FACL_ASSERT(a_valid_prefix, (valid_vec & (valid_vec + ENTRIES'(1))) == '0)
  `FACL_ASSERT_NEXT(a_miss_fills_head, shift, valid_vec[0] && (links[0].key == $past(key)))
  `FACL_ASSERT_IMP(a_evict_only_on_miss, out_valid_o && evicted_o, !hit_o)

endmodule

// File: tb/fifo_associative_cache_lookup_top_tb.sv
// Testbench for the fully associative FIFO-replacement cache lookup block.
// Depends on facl_pkg and fifo_associative_cache_lookup_top; drives lookups from a
// queue and checks every result against an in-bench model of the cache contents.
`timescale 1ns / 100ps

module fifo_associative_cache_lookup_top_tb;
  import facl_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned LONG_HOLD   = 60;
  localparam int unsigned POOL_SIZE   = 24;

  typedef struct packed {
    field_t key;
    field_t data;
  } lookup_req_t;

  typedef struct packed {
    field_t read_data;
    logic   hit;
    logic   evicted;
  } lookup_result_t;

  logic   clk_i         = 1'b0;
  logic   rst_ni        = 1'b0;
  logic   in_valid_i    = 1'b0;
  logic   in_stall_o;
  field_t lookup_key_i  = '0;
  field_t source_data_i = '0;
  logic   out_valid_o;
  logic   out_stall_i   = 1'b0;
  field_t read_data_o;
  logic   hit_o;
  logic   evicted_o;

  fifo_associative_cache_lookup_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .lookup_key_i  (lookup_key_i),
    .source_data_i (source_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_data_o   (read_data_o),
    .hit_o         (hit_o),
    .evicted_o     (evicted_o)
  );

  lookup_req_t    lookup_q[$];
  lookup_result_t expected_q[$];

  // Model of the cache: entries ordered oldest first.
  key_t  model_keys[ENTRIES];
  data_t model_data[ENTRIES];
  int    fill_level = 0;

  field_t key_pool[POOL_SIZE];

  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  bit    offer_taken   = 1'b0;
  bit    long_hold_arm = 1'b0;
  int    hold_left     = 0;
  int    error_count   = 0;
  int    lookups_done  = 0;
  int    hit_count     = 0;
  int    evict_count   = 0;
  int    quiet_cycles  = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic lookup_result_t cache_access(input field_t key_in, input field_t data_in);
    key_t           key;
    data_t          value;
    lookup_result_t res;
    int             match;
    key   = key_in[KEY_BITS-1:0];
    value = data_in[DATA_BITS-1:0];
    match = -1;
    for (int i = 0; i < fill_level; i++) begin
      if (match < 0 && model_keys[i] == key) match = i;
    end
    res.evicted = 1'b0;
    if (match >= 0) begin
      res.read_data = field_t'(model_data[match]);
      res.hit       = 1'b1;
    end else begin
      res.read_data = field_t'(value);
      res.hit       = 1'b0;
      if (fill_level == ENTRIES) begin
        for (int i = 0; i < ENTRIES - 1; i++) begin
          model_keys[i] = model_keys[i+1];
          model_data[i] = model_data[i+1];
        end
        model_keys[ENTRIES-1] = key;
        model_data[ENTRIES-1] = value;
        res.evicted = 1'b1;
      end else begin
        model_keys[fill_level] = key;
        model_data[fill_level] = value;
        fill_level++;
      end
    end
    return res;
  endfunction

  // Most keys come from a pool a little larger than the cache, so hits, misses
  // and evictions all occur; the pool drifts and some keys are fully random.
  function automatic lookup_req_t make_lookup();
    lookup_req_t req;
    if ($urandom_range(99) < 5) key_pool[$urandom_range(POOL_SIZE-1)] = $urandom();
    if ($urandom_range(99) < 80) req.key = key_pool[$urandom_range(POOL_SIZE-1)];
    else req.key = $urandom();
    req.data = $urandom();
    return req;
  endfunction

  task automatic add_lookup(input field_t key, input field_t value);
    lookup_q.push_back('{key: key, data: value});
  endtask

  // Sender: a new item is chosen only once the previous offer was taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || offer_taken) begin
      offer_taken = 1'b0;
      if (lookup_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i    <= 1'b1;
        lookup_key_i  <= lookup_q[0].key;
        source_data_i <= lookup_q[0].data;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off when armed.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (long_hold_arm) begin
      long_hold_arm = 1'b0;
      hold_left = LONG_HOLD - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Input side: predict each accepted lookup.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_q.push_back(cache_access(lookup_key_i, source_data_i));
      void'(lookup_q.pop_front());
      offer_taken = 1'b1;
    end
  end

  // Output side: compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    lookup_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with none expected: read_data %h hit %b evicted %b",
                                  read_data_o, hit_o, evicted_o));
      end else begin
        want = expected_q.pop_front();
        lookups_done++;
        if (want.hit) hit_count++;
        if (want.evicted) evict_count++;
        if (read_data_o !== want.read_data)
          report_mismatch($sformatf("read_data %h, expected %h", read_data_o, want.read_data));
        if (hit_o !== want.hit)
          report_mismatch($sformatf("hit %b, expected %b", hit_o, want.hit));
        if (evicted_o !== want.evicted)
          report_mismatch($sformatf("evicted %b, expected %b", evicted_o, want.evicted));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    int phase_items[3];
    phase_items = '{350, 350, 300};
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom();
    key_pool[0] = '0;
    key_pool[1] = '1;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extreme keys and data, hits on them, then fill the store and
    // force evictions so the oldest entry is dropped and the rest still answer.
    add_lookup(32'h0000_0000, 32'h0000_0000);
    add_lookup(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_lookup(32'h0000_0000, 32'h1234_5678);
    add_lookup(32'hFFFF_FFFF, 32'h0000_0000);
    for (int i = 1; i <= 14; i++) add_lookup(field_t'(i), 32'h1000_0000 + i);
    add_lookup(32'h0000_0100, 32'hDEAD_BEEF);
    add_lookup(32'h0000_0000, 32'hCAFE_F00D);
    add_lookup(32'h0000_0001, 32'h0BAD_0BAD);
    add_lookup(32'h0000_0100, 32'h0000_0000);
    add_lookup(32'hFFFF_FFFF, 32'h5555_AAAA);
    add_lookup(32'hA5A5_A5A5, 32'h5A5A_5A5A);
    while (lookup_q.size() != 0 || expected_q.size() != 0) @(posedge clk_i);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct = 86;
        end
        1: begin
          send_idle_pct = 86;
          recv_idle_pct = 35;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          long_hold_arm = 1'b1;
        end
      endcase
      repeat (phase_items[ph]) lookup_q.push_back(make_lookup());
      while (lookup_q.size() != 0 || expected_q.size() != 0) @(posedge clk_i);
    end

    repeat (5) @(posedge clk_i);
    if (expected_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_q.size()));

    $display("Checked %0d lookups: %0d hits, %0d misses, %0d of them with eviction.",
             lookups_done, hit_count, lookups_done - hit_count, evict_count);
    $display("Idle mixes: sender-heavy, receiver-heavy, none, with one long output hold-off.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
